@@ hdl/pcd_pkg.sv @@
`timescale 1ns / 1ps
// pcd_pkg: widths, register indexes, reset values, the token that moves
// along the cell chains, and the small helper functions of the decimator

package pcd_pkg;

  localparam int WORD_W        = 32;
  localparam int MAX_ORDER     = 8;
  localparam int MAX_RATIO     = 1024;
  localparam int ORDER_W       = 4;
  localparam int RATIO_W       = 11;
  localparam int GAIN_W        = 5;
  localparam int PHASE_W       = 10;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 3;
  localparam int SHIFT_W       = 5;
  localparam int GROWTH_W      = 7;
  localparam int PCM_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int DC_FRAC       = 8;
  localparam int BASE_SHIFT    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_GAIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_ORDER       = 2'd3;

  localparam logic [ORDER_W-1:0] RST_ORDER = 4'd4;
  localparam logic [RATIO_W-1:0] RST_RATIO = 11'd64;

  localparam logic signed [WORD_W-1:0] PCM_MAX = 32'sd32767;
  localparam logic signed [WORD_W-1:0] PCM_MIN = -32'sd32768;

  typedef struct packed {
    logic              vld;
    logic              fire;
    logic              last;
    logic [WORD_W-1:0] data;
  } pcd_tok_t;

  function automatic logic [ORDER_W-1:0] order_eff(input logic [ORDER_W-1:0] o);
    logic [ORDER_W-1:0] r;
    r = o;
    if (o == '0) r = ORDER_W'(1);
    else if (o > ORDER_W'(MAX_ORDER)) r = ORDER_W'(MAX_ORDER);
    return r;
  endfunction

  function automatic logic [RATIO_W-1:0] ratio_eff(input logic [RATIO_W-1:0] d);
    logic [RATIO_W-1:0] r;
    r = d;
    if (d == '0) r = RATIO_W'(1);
    else if (d > RATIO_W'(MAX_RATIO)) r = RATIO_W'(MAX_RATIO);
    return r;
  endfunction

  // ceil(log2(r)), r in 1..1024
  function automatic logic [3:0] clog2_ratio(input logic [RATIO_W-1:0] r);
    logic [RATIO_W-1:0] v;
    logic [3:0]         n;
    v = r - RATIO_W'(1);
    n = '0;
    for (int i = 0; i < RATIO_W; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  // min(31, max(0, order * clog2(ratio) - 15 - gain))
  function automatic logic [SHIFT_W-1:0] scale_shift(input logic [ORDER_W-1:0] o,
                                                     input logic [RATIO_W-1:0] d,
                                                     input logic [GAIN_W-1:0]  g);
    logic [GROWTH_W-1:0] growth;
    logic [GROWTH_W-1:0] lim;
    logic [GROWTH_W-1:0] diff;
    logic [SHIFT_W-1:0]  s;
    growth = GROWTH_W'(o) * GROWTH_W'(clog2_ratio(d));
    lim    = GROWTH_W'(BASE_SHIFT) + GROWTH_W'(g);
    diff   = growth - lim;
    if (growth <= lim) s = '0;
    else if (diff > GROWTH_W'(31)) s = SHIFT_W'(31);
    else s = diff[SHIFT_W-1:0];
    return s;
  endfunction

endpackage

@@ hdl/pcd_if.sv @@
`timescale 1ns / 1ps
// pcd_byte_if and pcd_pcm_if: valid/ready channels of the decimator
// depends on pcd_pkg for field widths

interface pcd_byte_if import pcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pdm_byte;
  modport source (output valid, output pdm_byte, input ready);
  modport sink   (input valid, input pdm_byte, output ready);
endinterface

interface pcd_pcm_if import pcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PCM_W-1:0] pcm_sample;
  logic                    last_of_byte;
  modport source (output valid, output pcm_sample, output last_of_byte, input ready);
  modport sink   (input valid, input pcm_sample, input last_of_byte, output ready);
endinterface

@@ hdl/pdm_cic_decimator_dc_block.sv @@
`timescale 1ns / 1ps
// pdm_cic_decimator_dc_block: pdm byte in, dc-blocked pcm samples out
// depends on pcd_pkg, pcd_if, pcd_integ_cell, pcd_comb_cell, pcd_dc_block
//
// byte_in carries one word of eight pdm bits; pcm_out carries one pcm sample
// per decimation period with last_of_byte marking the final sample that a
// byte produced. a byte yields zero to eight samples.
// the bit sequencer shifts one bit per cycle, unless the sink stalls, into a row
// of eight integrator cells, then a row of eight comb cells, then the scaling
// and dc stages; a new byte is taken at the edge that sends its predecessor's
// last bit, so back-to-back bytes follow with no idle bit between them.
// a sample's bit passes the bit register, the eight integrator cells, the
// eight comb cells, the scaling register and the output register to pcm_out.
// cfg_we/cfg_index/cfg_data write the four registers; write them only while
// no byte is in flight.
// reset clears all integrator, comb and dc state, the phase count, and puts
// the registers back to order 4, ratio 64, gain 0, msb first.
// when the sink stalls, the whole cell row holds in place; the sequencer
// may still take a byte while a finished sample waits.

module pdm_cic_decimator_dc_block import pcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pcd_byte_if.sink              byte_in,
  pcd_pcm_if.source             pcm_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ORDER_W-1:0] filter_order;
  logic [RATIO_W-1:0] decimation_ratio;
  logic [GAIN_W-1:0]  extra_gain_shift;
  logic               bit_order_lsb_first;

  logic [ORDER_W-1:0] order_e;
  logic [RATIO_W-1:0] ratio_e;
  logic [SHIFT_W-1:0] shift;

  logic               adv;
  logic               accept;
  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [BYTE_W-1:0]  sreg;
  logic [PHASE_W-1:0] phase;
  logic [RATIO_W-1:0] phase_inc;
  logic               cur_bit;
  logic               fire;
  logic               last;
  pcd_tok_t           bit_tok;

  pcd_tok_t integ_tok [MAX_ORDER+1];
  pcd_tok_t comb_tok  [MAX_ORDER+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order        <= RST_ORDER;
      decimation_ratio    <= RST_RATIO;
      extra_gain_shift    <= '0;
      bit_order_lsb_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_ORDER: filter_order        <= cfg_data[ORDER_W-1:0];
        REG_DECIMATION:   decimation_ratio    <= cfg_data[RATIO_W-1:0];
        REG_EXTRA_GAIN:   extra_gain_shift    <= cfg_data[GAIN_W-1:0];
        REG_BIT_ORDER:    bit_order_lsb_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign order_e = order_eff(filter_order);
  assign ratio_e = ratio_eff(decimation_ratio);
  assign shift   = scale_shift(order_e, ratio_e, extra_gain_shift);

  assign adv           = !pcm_out.valid || pcm_out.ready;
  assign byte_in.ready = !busy || (cnt == CNT_W'(BYTE_W - 1) && adv);
  assign accept        = byte_in.valid && byte_in.ready;

  // bit sequencer and decimation phase
  always_comb begin
    cur_bit   = bit_order_lsb_first ? sreg[cnt] : sreg[CNT_W'(BYTE_W - 1) - cnt];
    phase_inc = RATIO_W'(phase) + RATIO_W'(1);
    fire      = phase_inc >= ratio_e;
    // after a fire the next one is ratio bits away
    last      = fire && (cnt == CNT_W'(BYTE_W - 1) ||
                         ratio_e > RATIO_W'(CNT_W'(BYTE_W - 1) - cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= '0;
      phase       <= '0;
      bit_tok.vld <= 1'b0;
    end else begin
      if (adv) begin
        bit_tok.vld  <= busy;
        bit_tok.fire <= fire;
        bit_tok.last <= last;
        bit_tok.data <= cur_bit ? WORD_W'(1) : {WORD_W{1'b1}};
        if (busy) phase <= fire ? '0 : phase_inc[PHASE_W-1:0];
      end
      // a byte taken with its predecessor's last bit starts at bit zero
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
        sreg <= byte_in.pdm_byte;
      end else if (adv && busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(BYTE_W - 1)) busy <= 1'b0;
      end
    end
  end

  assign integ_tok[0] = bit_tok;

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_integ
    pcd_integ_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .active  (ORDER_W'(i) < order_e),
      .tok_in  (integ_tok[i]),
      .tok_out (integ_tok[i+1])
    );
  end

  // only decimated words enter the comb row
  always_comb begin
    comb_tok[0]     = integ_tok[MAX_ORDER];
    comb_tok[0].vld = integ_tok[MAX_ORDER].vld && integ_tok[MAX_ORDER].fire;
  end

  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_comb
    pcd_comb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .active  (ORDER_W'(i) < order_e),
      .tok_in  (comb_tok[i]),
      .tok_out (comb_tok[i+1])
    );
  end

  pcd_dc_block u_dc (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .shift    (shift),
    .tok_in   (comb_tok[MAX_ORDER]),
    .out_vld  (pcm_out.valid),
    .out_pcm  (pcm_out.pcm_sample),
    .out_last (pcm_out.last_of_byte)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && cnt == '0)
    else $error("accepted byte did not start the sequencer");

  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == CNT_W'(BYTE_W - 1) && adv && !accept |=> !busy)
    else $error("sequencer did not stop after the eighth bit");

  a_last_needs_fire: assert property (@(posedge clk) disable iff (rst)
    bit_tok.vld && !bit_tok.fire |-> !bit_tok.last)
    else $error("last flag on a bit that made no sample");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv && busy && !accept |=> $stable(cnt) && $stable(phase))
    else $error("sequencer moved while the pipeline was stalled");

endmodule

@@ hdl/pcd_integ_cell.sv @@
`timescale 1ns / 1ps
// pcd_integ_cell: one wrapping integrator of the chain, passes its sum on
// depends on pcd_pkg for the token type

module pcd_integ_cell import pcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     active,
  input  pcd_tok_t tok_in,
  output pcd_tok_t tok_out
);

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] acc_next;
  pcd_tok_t          tok_out_next;

  assign acc_next = acc + tok_in.data;

  // stages beyond the order pass the word untouched and keep their sum
  always_comb begin
    tok_out_next = tok_in;
    if (tok_in.vld && active) tok_out_next.data = acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_out_next;
      if (tok_in.vld && active) acc <= acc_next;
    end
  end

endmodule

@@ hdl/pcd_comb_cell.sv @@
`timescale 1ns / 1ps
// pcd_comb_cell: one wrapping comb stage, differentiates at the decimated rate
// depends on pcd_pkg for the token type

module pcd_comb_cell import pcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     active,
  input  pcd_tok_t tok_in,
  output pcd_tok_t tok_out
);

  logic [WORD_W-1:0] dly;
  pcd_tok_t          tok_out_next;

  always_comb begin
    tok_out_next = tok_in;
    if (tok_in.vld && active) tok_out_next.data = tok_in.data - dly;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly         <= '0;
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_out_next;
      if (tok_in.vld && active) dly <= tok_in.data;
    end
  end

endmodule

@@ hdl/pcd_dc_block.sv @@
`timescale 1ns / 1ps
// pcd_dc_block: output scaling shift, q8 one-pole dc blocker, int16 clamp
// and the output register; depends on pcd_pkg

module pcd_dc_block import pcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic [SHIFT_W-1:0]      shift,
  input  pcd_tok_t                tok_in,
  output logic                    out_vld,
  output logic signed [PCM_W-1:0] out_pcm,
  output logic                    out_last
);

  logic                     a_vld;
  logic                     a_last;
  logic signed [WORD_W-1:0] a_s;
  logic signed [WORD_W-1:0] y;
  logic signed [WORD_W-1:0] x1;
  logic signed [WORD_W-1:0] y_next;
  logic signed [WORD_W-1:0] y_int;
  logic signed [PCM_W-1:0]  pcm_next;

  always_comb begin
    y_next = ((a_s - x1) <<< DC_FRAC) + y - (y >>> DC_FRAC);
    y_int  = y_next >>> DC_FRAC;
    if (y_int > PCM_MAX) pcm_next = PCM_MAX[PCM_W-1:0];
    else if (y_int < PCM_MIN) pcm_next = PCM_MIN[PCM_W-1:0];
    else pcm_next = y_int[PCM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      out_vld <= 1'b0;
      y       <= '0;
      x1      <= '0;
    end else if (adv) begin
      a_vld   <= tok_in.vld;
      a_last  <= tok_in.last;
      a_s     <= $signed(tok_in.data) >>> shift;
      out_vld <= a_vld;
      if (a_vld) begin
        y        <= y_next;
        x1       <= a_s;
        out_pcm  <= pcm_next;
        out_last <= a_last;
      end
    end
  end

endmodule
